@@ sv/shifting_array_list_macros.svh @@
// Assertion helpers for the file that checks this block.
`ifndef SHIFTING_ARRAY_LIST_MACROS_SVH
`define SHIFTING_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SAL_ASSERT(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SAL_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sal_pkg.sv @@
package sal_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_INSERT    = 2'd1,
    OP_DEL_VALUE = 2'd2,
    OP_DEL_POS   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [30:0] value;
    logic [4:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [30:0] entry_value;
    logic [3:0]  entry_index;
    logic        last_entry;
    logic [4:0]  entry_count;
    status_e     op_status;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [30:0] value;
    logic [4:0]  position;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ sv/shifting_array_list.sv @@
// Ordered list of up to DEPTH values with append, insert at a 1-based
// position, delete by value and delete at position. Every transaction is
// answered by a dump of all DEPTH slots, index 0 first, with last_entry set
// on the final slot; entry_count and op_status repeat on each result. Each
// item is executed from the idle state and then dumped, the dump rotating
// the slot array by one slot per delivered result. A delete by value walks
// the held entries first, stepping past each kept entry and removing each
// match before the dump starts. A two-deep command queue between the
// decoder and the list engine lets the next transaction be taken while a
// dump runs.
// The store is cleared by reset itself; no clearing pass follows reset.
`include "shifting_array_list_macros.svh"

module shifting_array_list #(
  parameter int unsigned DEPTH = sal_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sal_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sal_pkg::out_item_t out_data_o
);
  import sal_pkg::*;

  cmd_t       front_cmd, head_cmd;
  fifo_stat_t q_stat;
  logic       push, pop;

  sal_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  sal_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .stat_o (q_stat)
  );

  sal_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!q_stat.empty),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `SAL_ASSERT(a_queue_no_overflow, push, !q_stat.full, "command queue pushed while full")
  `SAL_ASSERT(a_last_is_top_slot, out_valid_o && out_data_o.last_entry, out_data_o.entry_index == 4'(DEPTH - 1), "last entry flagged on wrong slot")
  `SAL_ASSERT_NEXT(a_dump_continues, out_valid_o && !out_stall_i && !out_data_o.last_entry, out_valid_o, "dump broke off before the last slot")

endmodule

@@ sv/sal_front.sv @@
module sal_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sal_pkg::in_item_t in_data_i,
  input  logic            q_full_i,
  output logic            push_o,
  output sal_pkg::cmd_t   cmd_o
);
  import sal_pkg::*;

  logic valid_q, valid_d;
  logic accept;
  cmd_t cmd_q;

  assign in_stall_o = valid_q && q_full_i;
  assign push_o     = valid_q && !q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op       <= op_e'(in_data_i.func);
      cmd_q.value    <= in_data_i.value;
      cmd_q.position <= in_data_i.position;
    end
  end

endmodule

@@ sv/sal_cmd_fifo.sv @@
module sal_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sal_pkg::cmd_t       data_i,
  input  logic                pop_i,
  output sal_pkg::cmd_t       data_o,
  output sal_pkg::fifo_stat_t stat_o
);
  import sal_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ sv/sal_back.sv @@
module sal_back #(
  parameter int unsigned DEPTH = sal_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sal_pkg::cmd_t      cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sal_pkg::out_item_t out_data_o
);
  import sal_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = ((CntW > 5) ? CntW : 5) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [30:0]     slot_q [DEPTH];
  logic [30:0]     slot_d [DEPTH];
  logic [30:0]     up_w   [DEPTH];
  logic [30:0]     dn_w   [DEPTH];
  logic [DEPTH-1:0] match_w;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] j_q, j_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [30:0]     val_q, val_d;
  status_e         stat_q, stat_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load, out_fire, is_full, is_last;
  logic [CmpW-1:0] pos_w, cnt_w, pm1_w, top_w;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign is_full     = (cnt_q >= CntW'(DEPTH));
  assign is_last     = (idx_q == IdxW'(DEPTH - 1));
  assign pos_w       = CmpW'(cmd_i.position);
  assign cnt_w       = CmpW'(cnt_q);
  assign pm1_w       = pos_w - CmpW'(1);
  assign top_w       = is_full ? CmpW'(DEPTH) : cnt_w + CmpW'(1);

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      up_w[k]    = slot_q[(k == 0) ? 0 : k - 1];
      dn_w[k]    = (k == DEPTH - 1) ? '0 : slot_q[(k == DEPTH - 1) ? k : k + 1];
      match_w[k] = (CntW'(k) < cnt_q) && (slot_q[k] == val_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    j_d      = j_q;
    idx_d    = idx_q;
    val_d    = val_q;
    stat_d   = stat_q;
    out_d    = out_q;
    out_load = 1'b0;
    cmd_pop_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          stat_d    = ST_DONE;
          state_d   = S_DUMP;
          case (cmd_i.op)
            OP_APPEND: begin
              if (is_full) begin
                stat_d = ST_FULL;
              end else begin
                for (int k = 0; k < DEPTH; k++) begin
                  if (CntW'(k) == cnt_q) begin
                    slot_d[k] = cmd_i.value;
                  end
                end
                cnt_d = cnt_q + CntW'(1);
              end
            end
            OP_INSERT: begin
              if ((pos_w == '0) || (pos_w > top_w)) begin
                stat_d = ST_RANGE;
              end else begin
                for (int k = 0; k < DEPTH; k++) begin
                  if (CmpW'(k) > pm1_w) begin
                    slot_d[k] = up_w[k];
                  end else if (CmpW'(k) == pm1_w) begin
                    slot_d[k] = cmd_i.value;
                  end
                end
                if (!is_full) begin
                  cnt_d = cnt_q + CntW'(1);
                end
              end
            end
            OP_DEL_VALUE: begin
              val_d   = cmd_i.value;
              j_d     = '0;
              state_d = S_SCAN;
            end
            OP_DEL_POS: begin
              if ((pos_w == '0) || (pos_w > cnt_w)) begin
                stat_d = ST_RANGE;
              end else begin
                for (int k = 0; k < DEPTH; k++) begin
                  if (CmpW'(k) >= pm1_w) begin
                    slot_d[k] = dn_w[k];
                  end
                end
                cnt_d = cnt_q - CntW'(1);
              end
            end
            default: begin
              stat_d = ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (j_q >= cnt_q) begin
          state_d = S_DUMP;
        end else if (match_w[j_q[IdxW-1:0]]) begin
          for (int k = 0; k < DEPTH; k++) begin
            if (CntW'(k) >= j_q) begin
              slot_d[k] = dn_w[k];
            end
          end
          cnt_d = cnt_q - CntW'(1);
        end else begin
          j_d = j_q + CntW'(1);
        end
      end
      S_DUMP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load          = 1'b1;
          out_d.entry_value = slot_q[0];
          out_d.entry_index = 4'(idx_q);
          out_d.last_entry  = is_last;
          out_d.entry_count = 5'(cnt_q);
          out_d.op_status   = stat_q;
          for (int k = 0; k < DEPTH; k++) begin
            slot_d[k] = slot_q[(k + 1) % DEPTH];
          end
          if (is_last) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_fire ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      idx_q       <= '0;
      stat_q      <= ST_DONE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
        slot_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      idx_q       <= idx_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

endmodule
